@@ sv/piecewise_linear_colormap_assert.svh @@
// Assertion macros shared by the colormap checkers.
`ifndef PIECEWISE_LINEAR_COLORMAP_ASSERT_SVH
`define PIECEWISE_LINEAR_COLORMAP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PLC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PLC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/plc_pkg.sv @@
// ----------------------------------------------------------------------------
// plc_pkg
// Shared constants, codes and types of the piecewise-linear colormap.
// ----------------------------------------------------------------------------
package plc_pkg;

	localparam int MAX_STOPS = 16;
	localparam int IDX_W     = $clog2(MAX_STOPS);
	localparam int CNT_W     = $clog2(MAX_STOPS + 1);
	localparam int POS_W     = 13;
	localparam int COL_W     = 32;
	localparam int ENT_W     = POS_W + COL_W;
	localparam int DVD_W     = 28;
	localparam int DVS_W     = 16;
	localparam int Q_FRAC    = 12;
	localparam logic [POS_W-1:0] Q_ONE = POS_W'(4096);

	// request kinds
	localparam logic [1:0] KIND_MAP = 2'd0;
	localparam logic [1:0] KIND_INS = 2'd1;
	localparam logic [1:0] KIND_CLR = 2'd2;
	localparam logic [1:0] KIND_IGN = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_RANGE  = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_BADRNG = 2'd3;

	// register indexes
	localparam logic REG_MIN = 1'b0;
	localparam logic REG_MAX = 1'b1;

	localparam logic [COL_W-1:0] WHITE = 32'hFFFF_FFFF;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PICK,
		S_NORM,
		S_SCAN,
		S_RATIO,
		S_LERP,
		S_FIND,
		S_SHIFT,
		S_DONE
	} state_t;

endpackage

@@ sv/plc_ram.sv @@
// ----------------------------------------------------------------------------
// plc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/plc_div.sv @@
// ----------------------------------------------------------------------------
// plc_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [plc_pkg::DVD_W-1:0]   dividend,
	input  logic [plc_pkg::DVS_W-1:0]   divisor,
	output logic                        done,
	output logic [plc_pkg::POS_W-1:0]   quotient
);

	localparam int CW = $clog2(plc_pkg::DVD_W + 1);

	logic [plc_pkg::DVD_W-1:0] quo_q;
	logic [plc_pkg::DVS_W:0]   rem_q;
	logic [plc_pkg::DVS_W-1:0] dvs_q;
	logic [CW-1:0]             cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [plc_pkg::DVS_W:0]   rem_sh;
	logic [plc_pkg::DVS_W+1:0] diff;

	// trial subtract
	assign rem_sh = {rem_q[plc_pkg::DVS_W-1:0], quo_q[plc_pkg::DVD_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(plc_pkg::DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[plc_pkg::DVS_W+1]) begin
				rem_q <= diff[plc_pkg::DVS_W:0];
				quo_q <= {quo_q[plc_pkg::DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[plc_pkg::DVD_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[plc_pkg::POS_W-1:0];

endmodule

@@ sv/piecewise_linear_colormap.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_colormap
// False-color engine over a sorted table of RGBA color stops.
// ----------------------------------------------------------------------------
//  channel | signals                          | moves
//  in      | in_valid/in_ready + 7 fields     | one request (map, insert, clear, ignore)
//  out     | out_valid/out_ready + 5 fields   | one result per request
//  cfg     | APB psel/penable/pwrite/paddr    | range_min at 0, range_max at 4
//
// A map request runs two 28-step divisions on the shared divider plus a scan
// over the stops. Insert scans the table, then shifts the RAM one entry at a
// time. Clear and trivial maps use neither the divider nor the scan.
// in_ready is high only while idle; a finished result waits in the output
// register. Reset empties the table and loads range_min=0, range_max=4096.
module piecewise_linear_colormap (
	input  logic                      clk,
	input  logic                      arst_n,
	// request channel
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                kind,
	input  logic signed [15:0]        sample_value,
	input  logic [12:0]               stop_position,
	input  logic [7:0]                stop_red,
	input  logic [7:0]                stop_green,
	input  logic [7:0]                stop_blue,
	input  logic [7:0]                stop_alpha,
	// result channel
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                out_red,
	output logic [7:0]                out_green,
	output logic [7:0]                out_blue,
	output logic [7:0]                out_alpha,
	output logic [1:0]                status,
	// config port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	localparam int IW = plc_pkg::IDX_W;
	localparam int CW = plc_pkg::CNT_W;
	localparam int PW = plc_pkg::POS_W;

	plc_pkg::state_t state_q, state_nx;

	logic signed [15:0] min_q, max_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q, at_q;
	logic               ph_q;
	logic [1:0]         ch_q;
	logic [PW-1:0]      npos_q;
	logic [31:0]        ncol_q;
	logic [PW-1:0]      p_q, r_q;
	logic [plc_pkg::ENT_W-1:0] prev_q;
	logic [31:0]        ci_q, cs_q;
	logic [7:0]         al_q;
	logic [23:0]        rgb_q;
	logic [31:0]        res_col_q;
	logic [1:0]         res_st_q;
	logic               out_valid_q;
	logic [31:0]        out_col_q;
	logic [1:0]         out_st_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= 16'sd0;
			max_q <= 16'sd4096;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				plc_pkg::REG_MIN: min_q <= pwdata[15:0];
				default:          max_q <= pwdata[15:0];
			endcase
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == plc_pkg::REG_MIN) ? {{16{min_q[15]}}, min_q}
	                                               : {{16{max_q[15]}}, max_q};

	// range and sample classification
	logic signed [16:0] span, off;
	logic               span_ok, at_low, at_high;
	assign span    = 17'(max_q) - 17'(min_q);
	assign off     = 17'(sample_value) - 17'(min_q);
	assign span_ok = (span > 17'sd0);
	assign at_low  = (sample_value <= min_q);
	assign at_high = (sample_value >= max_q);

	// stop table RAM: {position, color}
	logic                      ram_we;
	logic [IW-1:0]             ram_waddr, ram_raddr;
	logic [plc_pkg::ENT_W-1:0] ram_wdata, ram_rdata;
	logic [PW-1:0]             rd_pos;
	logic [31:0]               rd_col;

	plc_ram #(.WIDTH(plc_pkg::ENT_W), .DEPTH(plc_pkg::MAX_STOPS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_pos = ram_rdata[plc_pkg::ENT_W-1:32];
	assign rd_col = ram_rdata[31:0];

	// shared divider
	logic                      div_start, div_done;
	logic [plc_pkg::DVD_W-1:0] div_dvd;
	logic [plc_pkg::DVS_W-1:0] div_dvs;
	logic [PW-1:0]             div_quo;

	plc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// segment test on the entry just read
	logic [PW-1:0] lo_pos;
	logic          seg_hit, last_idx, ins_eq, ins_full, shift_end;
	assign lo_pos    = prev_q[plc_pkg::ENT_W-1:32];
	assign seg_hit   = (p_q >= lo_pos) && (p_q <= rd_pos);
	assign last_idx  = (idx_q + 1'b1 == count_q);
	assign ins_eq    = (rd_pos == npos_q);
	assign ins_full  = (count_q == CW'(plc_pkg::MAX_STOPS));
	assign shift_end = (idx_q == at_q);

	// one lerp channel per cycle
	logic [PW-1:0] r_inv;
	logic [20:0]   lerp_sum;
	assign r_inv    = plc_pkg::Q_ONE - r_q;
	assign lerp_sum = 21'(cs_q[31:24]) * 21'(r_q) + 21'(ci_q[31:24]) * 21'(r_inv);

	logic accept;
	assign accept = in_valid && in_ready;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			plc_pkg::S_IDLE: begin
				if (in_valid) begin
					case (kind)
						plc_pkg::KIND_MAP: begin
							if (!span_ok || count_q == '0) begin
								state_nx = plc_pkg::S_DONE;
							end else if (at_low || at_high || count_q == CW'(1)) begin
								state_nx = plc_pkg::S_PICK;
							end else begin
								state_nx = plc_pkg::S_NORM;
							end
						end
						plc_pkg::KIND_INS: begin
							if (stop_position > plc_pkg::Q_ONE) begin
								state_nx = plc_pkg::S_DONE;
							end else if (count_q == '0) begin
								state_nx = plc_pkg::S_SHIFT;
							end else begin
								state_nx = plc_pkg::S_FIND;
							end
						end
						default: state_nx = plc_pkg::S_DONE;
					endcase
				end
			end
			plc_pkg::S_PICK: if (ph_q) state_nx = plc_pkg::S_DONE;
			plc_pkg::S_NORM: if (div_done) state_nx = plc_pkg::S_SCAN;
			plc_pkg::S_SCAN: begin
				if (ph_q && idx_q != '0) begin
					if (seg_hit) begin
						state_nx = plc_pkg::S_RATIO;
					end else if (last_idx) begin
						state_nx = plc_pkg::S_DONE;
					end
				end
			end
			plc_pkg::S_RATIO: if (div_done) state_nx = plc_pkg::S_LERP;
			plc_pkg::S_LERP:  if (ch_q == 2'd2) state_nx = plc_pkg::S_DONE;
			plc_pkg::S_FIND: begin
				if (ph_q) begin
					if (ins_eq) begin
						state_nx = plc_pkg::S_DONE;
					end else if (last_idx) begin
						state_nx = ins_full ? plc_pkg::S_DONE : plc_pkg::S_SHIFT;
					end
				end
			end
			plc_pkg::S_SHIFT: if (shift_end) state_nx = plc_pkg::S_DONE;
			plc_pkg::S_DONE:  if (!out_valid_q || out_ready) state_nx = plc_pkg::S_IDLE;
			default:          state_nx = plc_pkg::S_IDLE;
		endcase
	end

	// control outputs: handshake, RAM, divider
	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q[IW-1:0];
		ram_wdata = {npos_q, ncol_q};
		ram_raddr = idx_q[IW-1:0];
		div_start = 1'b0;
		div_dvd   = {3'b000, p_q - lo_pos, 12'h000};
		div_dvs   = {3'b000, rd_pos - lo_pos};
		case (state_q)
			plc_pkg::S_IDLE: begin
				in_ready  = 1'b1;
				div_dvd   = {off[15:0], 12'h000};
				div_dvs   = span[15:0];
				div_start = in_valid && kind == plc_pkg::KIND_MAP && span_ok &&
				            count_q > CW'(1) && !at_low && !at_high;
			end
			plc_pkg::S_SCAN: div_start = ph_q && idx_q != '0 && seg_hit;
			plc_pkg::S_FIND: ram_we = ph_q && ins_eq;
			plc_pkg::S_SHIFT: begin
				ram_raddr = IW'(idx_q - 1'b1);
				if (shift_end) begin
					ram_we = 1'b1;
				end else if (ph_q) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata;
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= plc_pkg::S_IDLE;
			count_q     <= '0;
			ph_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				plc_pkg::S_IDLE: begin
					ph_q <= 1'b0;
					if (accept && kind == plc_pkg::KIND_CLR) begin
						count_q <= '0;
					end
				end
				plc_pkg::S_PICK, plc_pkg::S_SCAN, plc_pkg::S_FIND: ph_q <= !ph_q;
				plc_pkg::S_SHIFT: begin
					if (shift_end) begin
						count_q <= count_q + 1'b1;
						ph_q    <= 1'b0;
					end else begin
						ph_q <= !ph_q;
					end
				end
				default: ph_q <= 1'b0;
			endcase
			// output register
			if (state_q == plc_pkg::S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			plc_pkg::S_IDLE: begin
				npos_q    <= stop_position;
				ncol_q    <= {stop_red, stop_green, stop_blue, stop_alpha};
				res_col_q <= '0;
				res_st_q  <= plc_pkg::ST_OK;
				idx_q     <= '0;
				at_q      <= '0;
				ch_q      <= '0;
				if (kind == plc_pkg::KIND_MAP) begin
					if (!span_ok) begin
						res_st_q <= plc_pkg::ST_BADRNG;
					end else if (count_q == '0) begin
						res_col_q <= plc_pkg::WHITE;
					end else if (at_high && !at_low) begin
						idx_q <= count_q - 1'b1;
					end
				end else if (kind == plc_pkg::KIND_INS && stop_position > plc_pkg::Q_ONE) begin
					res_st_q <= plc_pkg::ST_RANGE;
				end
			end
			plc_pkg::S_PICK: if (ph_q) res_col_q <= rd_col;
			plc_pkg::S_NORM: if (div_done) p_q <= div_quo;
			plc_pkg::S_SCAN: begin
				if (ph_q) begin
					prev_q <= ram_rdata;
					idx_q  <= idx_q + 1'b1;
					ci_q   <= prev_q[31:0];
					cs_q   <= rd_col;
					al_q   <= 8'((9'(prev_q[7:0]) + 9'(rd_col[7:0])) >> 1);
					if (idx_q != '0 && !seg_hit && last_idx) begin
						res_col_q <= plc_pkg::WHITE;
					end
				end
			end
			plc_pkg::S_RATIO: if (div_done) r_q <= div_quo;
			plc_pkg::S_LERP: begin
				ch_q  <= ch_q + 1'b1;
				ci_q  <= ci_q << 8;
				cs_q  <= cs_q << 8;
				rgb_q <= {rgb_q[15:0], lerp_sum[19:12]};
				if (ch_q == 2'd2) begin
					res_col_q <= {rgb_q[15:0], lerp_sum[19:12], al_q};
				end
			end
			plc_pkg::S_FIND: begin
				if (ph_q) begin
					idx_q <= idx_q + 1'b1;
					if (rd_pos < npos_q) begin
						at_q <= at_q + 1'b1;
					end
					if (!ins_eq && last_idx) begin
						idx_q <= count_q;
						if (ins_full) begin
							res_st_q <= plc_pkg::ST_FULL;
						end
					end
				end
			end
			plc_pkg::S_SHIFT: if (ph_q && !shift_end) idx_q <= idx_q - 1'b1;
			plc_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_col_q <= res_col_q;
					out_st_q  <= res_st_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_red   = out_col_q[31:24];
	assign out_green = out_col_q[23:16];
	assign out_blue  = out_col_q[15:8];
	assign out_alpha = out_col_q[7:0];
	assign status    = out_st_q;

endmodule

@@ sv/plc_chk.sv @@
// ----------------------------------------------------------------------------
// plc_chk
// Port-level checks of the colormap, bound to the top level.
// ----------------------------------------------------------------------------
`include "piecewise_linear_colormap_assert.svh"

module plc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_red,
	input logic [7:0]  out_green,
	input logic [7:0]  out_blue,
	input logic [7:0]  out_alpha,
	input logic [1:0]  status,
	input logic        pready
);

	// a taken request holds off the next one
	`PLC_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready after request")

	// failed requests carry no color
	`PLC_ASSERT_NOW(a_err_no_color, out_valid && status != plc_pkg::ST_OK, {out_red, out_green, out_blue, out_alpha} == 32'd0, "color on error")

	// a stalled result holds
	`PLC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(out_red) && $stable(out_alpha), "stalled result changed")

	// config port never waits
	`PLC_ASSERT_NOW(a_pready, 1'b1, pready, "pready low")

endmodule

bind piecewise_linear_colormap plc_chk u_plc_chk (.*);
